// ----- src/in_order_release_buffer_core_defines.svh -----
// Assertion helpers for the in-order release buffer RTL.
`ifndef IN_ORDER_RELEASE_BUFFER_CORE_DEFINES_SVH
`define IN_ORDER_RELEASE_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IORB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("in-order release buffer: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IORB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("in-order release buffer: next-cycle check failed");

`endif

// ----- src/iorb_pkg.sv -----
package iorb_pkg;

  localparam int unsigned SEQ_W = 32;

  localparam logic [SEQ_W-1:0] TOP_SEQ   = 32'hFFFF_FFFF;
  localparam logic [SEQ_W-1:0] FIRST_SEQ = 32'd1;
  localparam logic [SEQ_W-1:0] ZERO_SEQ  = 32'd0;

  localparam logic STATUS_RELEASED = 1'b0;
  localparam logic STATUS_DROPPED  = 1'b1;

  // Operations of the shared adder
  typedef enum logic {
    ALU_SUB,
    ALU_INC
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [SEQ_W-1:0]  a;
    logic [SEQ_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  sum;
    logic              carry;  // on subtract: a >= b
  } alu_rsp_t;

  // Commands to the pending bitmap
  typedef struct packed {
    logic set;
    logic shift;
    logic clr;
  } mask_cmd_t;

endpackage

// ----- src/in_order_release_buffer_core.sv -----
// In-order release buffer core.
// Input: a sequence number on seq_num_i is taken at a rising edge with start
// high and busy low. busy stays high while the number is processed.
// Output: each result shows on out_seq_o, status_o and last_o for exactly one
// cycle with valid_o high; the receiver takes it at the end of that cycle and
// cannot hold it off. status_o high marks a number dropped beyond the window.
// Timing: the compare state matches the number against the expected one on
// the shared adder. Ignored, pending and dropped numbers then free the block;
// a number that completes a run moves on to the release state, which hands
// out one released number per cycle on the same adder until the run ends.
// Results are registered and show in the cycle after the step that makes
// them, consecutively, with last_o on the final one.
// Reset: nothing pending, 1 expected next, no result shown.
`include "in_order_release_buffer_core_defines.svh"

module in_order_release_buffer_core #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [iorb_pkg::SEQ_W-1:0]    seq_num_i,
  output logic                          valid_o,
  output logic [iorb_pkg::SEQ_W-1:0]    out_seq_o,
  output logic                          status_o,
  output logic                          last_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_REL  = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [iorb_pkg::SEQ_W-1:0]  seq_q;
  logic [iorb_pkg::SEQ_W-1:0]  next_exp_q, next_exp_d;
  logic                        valid_q, valid_d;
  logic [iorb_pkg::SEQ_W-1:0]  out_seq_q, out_seq_d;
  logic                        status_q, status_d;
  logic                        last_q, last_d;

  iorb_pkg::alu_req_t   alu_req;
  iorb_pkg::alu_rsp_t   alu_rsp;
  iorb_pkg::mask_cmd_t  mask_cmd;
  logic                 next_pend;

  logic accept;
  logic in_ok;
  logic far;
  logic hit;
  logic at_top;
  logic rel_last;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Drive the shared adder: distance in compare, increment in release
  always_comb begin
    alu_req.op = (state_q == ST_REL) ? iorb_pkg::ALU_INC : iorb_pkg::ALU_SUB;
    alu_req.a  = (state_q == ST_REL) ? next_exp_q : seq_q;
    alu_req.b  = next_exp_q;
  end

  iorb_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Classify the arrival
  assign in_ok    = (seq_q != iorb_pkg::ZERO_SEQ) && alu_rsp.carry;
  assign far      = (alu_rsp.sum >= iorb_pkg::SEQ_W'(WINDOW));
  assign hit      = (alu_rsp.sum == iorb_pkg::ZERO_SEQ);
  assign at_top   = (next_exp_q == iorb_pkg::TOP_SEQ);
  assign rel_last = at_top || !next_pend;

  always_comb begin
    mask_cmd.set   = (state_q == ST_CMP) && in_ok && !far && !hit;
    mask_cmd.shift = (state_q == ST_REL) && !at_top;
    mask_cmd.clr   = (state_q == ST_REL) && at_top;
  end

  iorb_mask #(
    .WINDOW (WINDOW)
  ) u_mask (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (mask_cmd),
    .set_idx_i   (alu_rsp.sum[IDX_W-1:0]),
    .next_pend_o (next_pend)
  );

  // Sequencer, expected number and result register
  always_comb begin
    state_d    = state_q;
    next_exp_d = next_exp_q;
    valid_d    = 1'b0;
    out_seq_d  = out_seq_q;
    status_d   = status_q;
    last_d     = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_IDLE;
        if (in_ok && far) begin
          valid_d   = 1'b1;
          out_seq_d = seq_q;
          status_d  = iorb_pkg::STATUS_DROPPED;
          last_d    = 1'b1;
        end else if (in_ok && hit) begin
          state_d = ST_REL;
        end
      end
      ST_REL: begin
        valid_d    = 1'b1;
        out_seq_d  = next_exp_q;
        status_d   = iorb_pkg::STATUS_RELEASED;
        last_d     = rel_last;
        next_exp_d = at_top ? iorb_pkg::FIRST_SEQ : alu_rsp.sum;
        if (rel_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      next_exp_q <= iorb_pkg::FIRST_SEQ;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      next_exp_q <= next_exp_d;
      valid_q    <= valid_d;
    end
  end

  // Hold the arrival and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q <= seq_num_i;
    end
    out_seq_q <= out_seq_d;
    status_q  <= status_d;
    last_q    <= last_d;
  end

  assign valid_o   = valid_q;
  assign out_seq_o = out_seq_q;
  assign status_o  = status_q;
  assign last_o    = last_q;

  `IORB_ASSERT_NOW(a_drop_is_last, clk_i, rst_ni, valid_o && status_o, last_o)
  `IORB_ASSERT_NEXT(a_accept_compares, clk_i, rst_ni, accept, state_q == ST_CMP)
  `IORB_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, valid_o && !status_o && !last_o,
                    valid_o && !status_o && (out_seq_o == $past(out_seq_o) + 32'd1))

endmodule

// ----- src/iorb_alu.sv -----
module iorb_alu (
  input  iorb_pkg::alu_req_t req_i,
  output iorb_pkg::alu_rsp_t rsp_o
);

  logic [iorb_pkg::SEQ_W:0] res;

  // Shared adder: distance to the expected number, or the increment of it
  always_comb begin
    case (req_i.op)
      iorb_pkg::ALU_SUB: res = {1'b0, req_i.a} + {1'b0, ~req_i.b} + 33'd1;
      iorb_pkg::ALU_INC: res = {1'b0, req_i.a} + 33'd1;
      default:           res = {1'b0, req_i.a};
    endcase
  end

  assign rsp_o.sum   = res[iorb_pkg::SEQ_W-1:0];
  assign rsp_o.carry = res[iorb_pkg::SEQ_W];

endmodule

// ----- src/iorb_mask.sv -----
module iorb_mask #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  iorb_pkg::mask_cmd_t         cmd_i,
  input  logic [$clog2(WINDOW)-1:0]   set_idx_i,
  output logic                        next_pend_o
);

  logic [WINDOW-1:0] mask_q, mask_d;

  // Clear on wrap, advance the window by one on release, mark arrivals pending
  always_comb begin
    mask_d = mask_q;
    if (cmd_i.clr) begin
      mask_d = '0;
    end else if (cmd_i.shift) begin
      mask_d = (mask_q >> 1) & ~WINDOW'(1);
    end else if (cmd_i.set) begin
      mask_d[set_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Number after the one being released is already here
  assign next_pend_o = mask_q[1];

endmodule
